@@ hw/rtl/pmc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern match counter package
// Shared field widths, register indexes, the result word type and the
// pattern byte lookup.
// ----------------------------------------------------------------------------
package pmc_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_CFG_W   = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 2;
  localparam int START_W     = 10;
  localparam int COUNT_W     = 11;
  localparam int FIRST_W     = 11;

  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LO  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HI  = 2'd2;

  typedef struct packed {
    logic                      match_ends_here;
    logic [START_W-1:0]        match_start;
    logic [COUNT_W-1:0]        match_count;
    logic signed [FIRST_W-1:0] first_position;
    logic                      text_done;
    logic                      text_too_long;
  } pmc_result_t;

  // Byte k of the pattern; bytes 0 to 7 sit in the low register.
  function automatic logic [BYTE_W-1:0] pattern_byte(input logic [CFG_DATA_W-1:0] lo,
                                                    input logic [CFG_DATA_W-1:0] hi,
                                                    input logic [3:0]            k);
    logic [CFG_DATA_W-1:0] src;
    src = k[3] ? hi : lo;
    return src[{k[2:0], 3'b000} +: BYTE_W];
  endfunction

endpackage

@@ hw/rtl/pattern_match_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern match counter
// Streaming non-overlapping substring counter over a byte stream.
// ----------------------------------------------------------------------------
// Path: an accepted word waits in the input register and moves into the result
// register when the output is empty or being read.
// Throughput: one word per cycle unless the output stalls; both registers
// advance together and the window compare fits between them.
// Reset: rst clears the pipeline, the text state and the pattern registers;
// the byte window needs no clearing and no clearing pass is run.
module pattern_match_counter_top #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_TEXT    = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [pmc_pkg::BYTE_W-1:0]          text_byte,
  input  logic                                end_of_text,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                match_ends_here,
  output logic [pmc_pkg::START_W-1:0]         match_start,
  output logic [pmc_pkg::COUNT_W-1:0]         match_count,
  output logic signed [pmc_pkg::FIRST_W-1:0]  first_position,
  output logic                                text_done,
  output logic                                text_too_long,
  input  logic                                cfg_we,
  input  logic [pmc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pmc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pmc_pkg::*;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  logic [LEN_CFG_W-1:0]  pattern_len;
  logic [CFG_DATA_W-1:0] pattern_lo;
  logic [CFG_DATA_W-1:0] pattern_hi;
  logic [LEN_W-1:0]      len;

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              advance;
  logic              win_match;
  pmc_result_t       result;

  // Lengths above the window depth are treated as the full window.
  assign len = (pattern_len > LEN_CFG_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN)
                                                       : LEN_W'(pattern_len);

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len <= '0;
      pattern_lo  <= '0;
      pattern_hi  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PATTERN_LEN: pattern_len <= cfg_data[LEN_CFG_W-1:0];
        CFG_PATTERN_LO:  pattern_lo  <= cfg_data;
        CFG_PATTERN_HI:  pattern_hi  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte <= text_byte;
      in_last <= end_of_text;
    end
  end

  pmc_window #(
    .MAX_PATTERN (MAX_PATTERN),
    .LEN_W       (LEN_W)
  ) u_window (
    .clk        (clk),
    .step       (advance),
    .text_byte  (in_byte),
    .len        (len),
    .pattern_lo (pattern_lo),
    .pattern_hi (pattern_hi),
    .win_match  (win_match)
  );

  pmc_tracker #(
    .MAX_TEXT (MAX_TEXT),
    .LEN_W    (LEN_W)
  ) u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .last      (in_last),
    .win_match (win_match),
    .len       (len),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      match_ends_here <= result.match_ends_here;
      match_start     <= result.match_start;
      match_count     <= result.match_count;
      first_position  <= result.first_position;
      text_done       <= result.text_done;
      text_too_long   <= result.text_too_long;
    end
  end

  a_hit_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_ends_here |-> match_count != '0)
    else $error("counted match reported with a zero count");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !match_ends_here |-> match_start == '0)
    else $error("match start not zero on a word without a match");

  a_first_set: assert property (@(posedge clk) disable iff (rst)
    out_valid && match_ends_here |-> first_position != '1)
    else $error("first position still unset after a counted match");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    in_full && out_valid && !out_ready |=> in_full && out_valid)
    else $error("pipeline dropped a word while the output was stalled");

endmodule

@@ hw/rtl/pmc_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern match counter byte window
// Shift register of the most recent text bytes and the parallel compare of
// the pattern against the window with the incoming byte shifted in.
// ----------------------------------------------------------------------------
module pmc_window #(
  parameter int MAX_PATTERN = 16,
  parameter int LEN_W       = 5
) (
  input  logic                            clk,
  input  logic                            step,
  input  logic [pmc_pkg::BYTE_W-1:0]      text_byte,
  input  logic [LEN_W-1:0]                len,
  input  logic [pmc_pkg::CFG_DATA_W-1:0]  pattern_lo,
  input  logic [pmc_pkg::CFG_DATA_W-1:0]  pattern_hi,
  output logic                            win_match
);
  import pmc_pkg::*;

  // Entry 0 is the newest byte.
  logic [BYTE_W-1:0] window      [MAX_PATTERN];
  logic [BYTE_W-1:0] window_next [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] len_eq;

  always_comb begin
    window_next[0] = text_byte;
    for (int i = 1; i < MAX_PATTERN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  // One full compare per candidate length, then the configured length picks.
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      len_eq[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (pattern_byte(pattern_lo, pattern_hi, 4'(k)) != window_next[l-1-k]) begin
          len_eq[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    win_match = 1'b0;
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      if (len == LEN_W'(l)) begin
        win_match = len_eq[l-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      window <= window_next;
    end
  end

endmodule

@@ hw/rtl/pmc_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern match counter text tracker
// Position, overlap skip, saturating count, first start and overflow state
// of the current text, and the result word for each byte.
// ----------------------------------------------------------------------------
module pmc_tracker #(
  parameter int MAX_TEXT = 1024,
  parameter int LEN_W    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 last,
  input  logic                 win_match,
  input  logic [LEN_W-1:0]     len,
  output pmc_pkg::pmc_result_t result
);
  import pmc_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT + 1);

  logic [POS_W-1:0] pos, pos_next;
  logic [LEN_W-1:0] skip, skip_next;
  logic [POS_W-1:0] count, count_next;
  logic [POS_W-1:0] first, first_next;
  logic             found, found_next;
  logic             ovf, ovf_next;
  logic             hit;
  logic [POS_W-1:0] start;
  logic             enough;
  logic [31:0]      start_wide;
  logic [31:0]      count_wide;
  logic [31:0]      first_wide;

  assign enough = ((POS_W+1)'(pos) + (POS_W+1)'(1)) >= (POS_W+1)'(len);

  always_comb begin
    pos_next   = pos;
    skip_next  = skip;
    count_next = count;
    first_next = first;
    found_next = found;
    ovf_next   = ovf;
    hit        = 1'b0;
    start      = '0;
    if (pos == POS_W'(MAX_TEXT)) begin
      // Past the maximum length the position holds and nothing matches.
      ovf_next = 1'b1;
    end else begin
      pos_next = pos + POS_W'(1);
      if (skip != '0) begin
        skip_next = skip - LEN_W'(1);
      end else if (len != '0 && enough && win_match) begin
        hit       = 1'b1;
        start     = pos + POS_W'(1) - POS_W'(len);
        skip_next = len - LEN_W'(1);
        if (count != POS_W'(MAX_TEXT)) begin
          count_next = count + POS_W'(1);
        end
        if (!found) begin
          found_next = 1'b1;
          first_next = start;
        end
      end
    end
  end

  always_comb begin
    start_wide = 32'(start);
    count_wide = 32'(count_next);
    first_wide = 32'(first_next);
    result.match_ends_here = hit;
    result.match_start     = start_wide[START_W-1:0];
    result.match_count     = count_wide[COUNT_W-1:0];
    result.first_position  = found_next ? first_wide[FIRST_W-1:0] : '1;
    result.text_done       = last;
    result.text_too_long   = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      skip  <= '0;
      count <= '0;
      first <= '0;
      found <= 1'b0;
      ovf   <= 1'b0;
    end else if (step) begin
      if (last) begin
        pos   <= '0;
        skip  <= '0;
        count <= '0;
        first <= '0;
        found <= 1'b0;
        ovf   <= 1'b0;
      end else begin
        pos   <= pos_next;
        skip  <= skip_next;
        count <= count_next;
        first <= first_next;
        found <= found_next;
        ovf   <= ovf_next;
      end
    end
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pattern match counter testbench
// Streams text words through the block under random valid/ready idling and
// checks every result word against a cycle-free software copy of the
// non-overlapping match counter, across several pattern settings.
// ----------------------------------------------------------------------------
module tb_top;
  import pmc_pkg::*;

  localparam int PATTERN_MAX  = 16;
  localparam int TEXT_MAX     = 1024;
  localparam int IDLE_PCT     = 26;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 250;

  // Index 3 decodes to no register.
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

  typedef logic [BYTE_W-1:0] text_q_t[$];

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [BYTE_W-1:0]      text_byte = '0;
  logic                   end_of_text = 1'b0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   match_ends_here;
  logic [START_W-1:0]     match_start;
  logic [COUNT_W-1:0]     match_count;
  logic signed [FIRST_W-1:0] first_position;
  logic                   text_done;
  logic                   text_too_long;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  pattern_match_counter_top #(
    .MAX_PATTERN(PATTERN_MAX),
    .MAX_TEXT   (TEXT_MAX)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_byte      (text_byte),
    .end_of_text    (end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_ends_here(match_ends_here),
    .match_start    (match_start),
    .match_count    (match_count),
    .first_position (first_position),
    .text_done      (text_done),
    .text_too_long  (text_too_long),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Software copy of the matcher: pattern registers and per-text state.
  logic [LEN_CFG_W-1:0]  pat_len_reg = '0;
  logic [CFG_DATA_W-1:0] pat_lo_reg = '0;
  logic [CFG_DATA_W-1:0] pat_hi_reg = '0;
  logic [BYTE_W-1:0]     recent_bytes [PATTERN_MAX];
  int unsigned           text_pos;
  int unsigned           skip_left;
  int unsigned           hit_total;
  int                    first_hit;
  bit                    text_overflow;

  pmc_result_t expected_q[$];
  int          errors = 0;
  bit          steady = 1'b0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  function automatic void clear_text_state();
    for (int i = 0; i < PATTERN_MAX; i++) recent_bytes[i] = '0;
    text_pos      = 0;
    skip_left     = 0;
    hit_total     = 0;
    first_hit     = -1;
    text_overflow = 1'b0;
  endfunction

  function automatic void apply_config(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_PATTERN_LEN: pat_len_reg = data[LEN_CFG_W-1:0];
      CFG_PATTERN_LO:  pat_lo_reg = data;
      CFG_PATTERN_HI:  pat_hi_reg = data;
      default: ;
    endcase
  endfunction

  function automatic pmc_result_t predict_match(input logic [BYTE_W-1:0] b, input logic last);
    pmc_result_t r;
    int unsigned len;
    int unsigned here;
    logic [BYTE_W-1:0] pb;
    bit equal;
    r = '0;
    len = (pat_len_reg > PATTERN_MAX) ? PATTERN_MAX : pat_len_reg;
    here = text_pos;
    for (int i = PATTERN_MAX - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (here >= TEXT_MAX) begin
      text_overflow = 1'b1;
    end else begin
      text_pos = here + 1;
      if (skip_left > 0) begin
        skip_left--;
      end else if (len > 0 && here + 1 >= len) begin
        equal = 1'b1;
        for (int unsigned k = 0; k < len; k++) begin
          pb = (k < 8) ? pat_lo_reg[8*k +: 8] : pat_hi_reg[8*(k-8) +: 8];
          if (pb != recent_bytes[len-1-k]) equal = 1'b0;
        end
        if (equal) begin
          r.match_ends_here = 1'b1;
          r.match_start = START_W'(here + 1 - len);
          skip_left = len - 1;
          if (hit_total < TEXT_MAX) hit_total++;
          if (first_hit < 0) first_hit = int'(here + 1 - len);
        end
      end
    end
    r.match_count    = COUNT_W'(hit_total);
    r.first_position = FIRST_W'(first_hit);
    r.text_done      = last;
    r.text_too_long  = text_overflow;
    if (last) clear_text_state();
    return r;
  endfunction

  initial clear_text_state();

  // Track register writes and accepted text words at the same edge the block does.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) apply_config(cfg_index, cfg_data);
      if (in_valid && in_ready) expected_q.push_back(predict_match(text_byte, end_of_text));
    end
  end

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    pmc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t ns: result word with no expected result, expected none actual 0x%0h",
                 $time, {match_ends_here, match_start, match_count, first_position,
                 text_done, text_too_long});
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("match_ends_here", 32'(want.match_ends_here), 32'(match_ends_here));
        check_field("match_start", 32'(want.match_start), 32'(match_start));
        check_field("match_count", 32'(want.match_count), 32'(match_count));
        check_field("first_position", 32'(unsigned'(want.first_position)),
                    32'(unsigned'(first_position)));
        check_field("text_done", 32'(want.text_done), 32'(text_done));
        check_field("text_too_long", 32'(want.text_too_long), 32'(text_too_long));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever the sequence asks.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(input text_q_t txt);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  // Sender pauses until every expected result word has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_pattern(input int len, input logic [CFG_DATA_W-1:0] lo,
                             input logic [CFG_DATA_W-1:0] hi);
    write_reg(CFG_PATTERN_LEN, CFG_DATA_W'(len));
    write_reg(CFG_PATTERN_LO, lo);
    write_reg(CFG_PATTERN_HI, hi);
    cfg_we <= 1'b0;
  endtask

  // Reset leaves the pattern empty, so even zero bytes must never match.
  task automatic test_empty_pattern();
    send_text('{8'h00, 8'h00, 8'hFF});
    wait_idle();
  endtask

  task automatic test_single_byte();
    set_pattern(1, 64'hFF, 64'h0);
    send_text('{8'hFF, 8'h00, 8'hFF});
    wait_idle();
  endtask

  // After a counted match the next L-1 positions cannot end another one.
  task automatic test_overlap();
    set_pattern(2, 64'h6161, 64'h0);
    send_text('{8'h61, 8'h61, 8'h61, 8'h61, 8'h61});
    wait_idle();
    set_pattern(3, 64'h616261, 64'h0);
    send_text('{8'h61, 8'h62, 8'h61, 8'h62, 8'h61});
    wait_idle();
  endtask

  // Pattern 00 00 05 would match the zeroed window if the prefix were not guarded.
  task automatic test_short_prefix();
    set_pattern(3, 64'h050000, 64'h0);
    send_text('{8'h05});
    send_text('{8'h00, 8'h05});
    send_text('{8'h00, 8'h00, 8'h05});
    wait_idle();
  endtask

  // Length 31 is clamped to the full 16-byte pattern.
  task automatic test_oversized_pattern();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    text_q_t txt;
    lo = 64'h0123456789ABCDEF;
    hi = 64'hFEDCBA9876543210;
    set_pattern(31, lo, hi);
    txt.push_back(8'h00);
    for (int k = 0; k < PATTERN_MAX; k++) txt.push_back(k < 8 ? lo[8*k +: 8] : hi[8*(k-8) +: 8]);
    send_text(txt);
    wait_idle();
  endtask

  task automatic test_unused_index();
    write_reg(CFG_UNUSED, '1);
    set_pattern(1, 64'h51, 64'h0);
    send_text('{8'h51, 8'h52});
    wait_idle();
  endtask

  // A new pattern applies from the next word while the window keeps its bytes.
  task automatic test_config_mid_text();
    set_pattern(2, 64'h7978, 64'h0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    wait_idle();
    set_pattern(3, 64'h636261, 64'h0);
    send_byte(8'h63, 1'b1);
    wait_idle();
  endtask

  // Every position matches until the length limit; later words never match.
  task automatic test_too_long_text();
    text_q_t txt;
    set_pattern(1, 64'h5A, 64'h0);
    repeat (TEXT_MAX + 6) txt.push_back(8'h5A);
    steady = 1'b1;
    send_text(txt);
    wait_idle();
    steady = 1'b0;
  endtask

  // The receiver holds off while words keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    text_q_t txt;
    set_pattern(2, 64'h6261, 64'h0);
    hold_requests <= hold_requests + 1;
    repeat (40) txt.push_back($urandom_range(1) ? 8'h61 : 8'h62);
    send_text(txt);
    wait_idle();
  endtask

  task automatic test_random_texts();
    int sent;
    int pick;
    int len;
    int eff;
    int n;
    int cut;
    bit narrow;
    logic [BYTE_W-1:0] pat [PATTERN_MAX];
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    text_q_t txt;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) len = 0;
      else if (pick < 10) len = $urandom_range(31, 17);
      else if (pick < 18) len = PATTERN_MAX;
      else len = $urandom_range(8, 1);
      eff = (len > PATTERN_MAX) ? PATTERN_MAX : len;
      narrow = ($urandom_range(99) < 60);
      for (int k = 0; k < PATTERN_MAX; k++)
        pat[k] = narrow ? ($urandom_range(1) ? 8'h61 : 8'h62) : BYTE_W'($urandom);
      for (int k = 0; k < 8; k++) begin
        lo[8*k +: 8] = pat[k];
        hi[8*k +: 8] = pat[k+8];
      end
      set_pattern(len, lo, hi);
      steady = ($urandom_range(9) == 0);
      repeat ($urandom_range(4, 1)) begin
        txt.delete();
        n = $urandom_range(40, 1);
        while (txt.size() < n) begin
          pick = $urandom_range(99);
          if (pick < 50 && eff > 0) begin
            for (int k = 0; k < eff; k++) txt.push_back(pat[k]);
          end else if (pick < 75 && eff > 1) begin
            // Broken occurrence: a proper prefix of the pattern.
            cut = $urandom_range(eff - 1, 1);
            for (int k = 0; k < cut; k++) txt.push_back(pat[k]);
          end else if (narrow && pick < 90) begin
            txt.push_back($urandom_range(1) ? 8'h61 : 8'h62);
          end else begin
            txt.push_back(BYTE_W'($urandom));
          end
        end
        send_text(txt);
        sent += txt.size();
      end
      wait_idle();
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_pattern();
    test_single_byte();
    test_overlap();
    test_short_prefix();
    test_oversized_pattern();
    test_unused_index();
    test_config_mid_text();
    test_too_long_text();
    test_backpressure();
    test_random_texts();
    wait_idle();
    if (expected_q.size() != 0) begin
      $display("%0t ns: results missing, expected %0d more actual 0", $time, expected_q.size());
    end
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
